// ===== rtl/core/mie_pkg.sv =====
// shared types and constants of the modular inverse core
package mie_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_IDX_W = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_MODULUS = REG_IDX_W'(0);
  localparam logic [DATA_W-1:0] MODULUS_RESET = DATA_W'(1000000007);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_REDUCE,
    ST_REDUCE_WAIT,
    ST_FINISH
  } seq_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/core/mie_in_if.sv =====
// input item channel of the modular inverse core
interface mie_in_if
  import mie_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/core/mie_out_if.sv =====
// result item channel of the modular inverse core
interface mie_out_if
  import mie_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] inverse;
  logic [DATA_W-1:0] common_divisor;
  logic              not_invertible;

  modport source (output valid, output inverse, output common_divisor,
                  output not_invertible, input ready);
  modport sink (input valid, input inverse, input common_divisor,
                input not_invertible, output ready);
endinterface

// ===== rtl/core/modular_inverse_ext_euclid_core.sv =====
// modular inverse core: extended euclid on one shared iterative divider
//
// Computes, for each input item value, the gcd of value and the modulus register
// and the bezout coefficient x of value (value*x + modulus*y = gcd) reduced into
// 0..modulus-1, plus a flag set when the gcd is not 1 (x is then still reported).
// Only the low VALUE_BITS bits of value and modulus are used. A modulus of zero
// gives gcd = value and inverse 0. Every euclid step runs one restoring division
// on the shared divider, one quotient bit per cycle, and forms q*s on the same
// pass by a horner accumulation; the final reduction of the coefficient is one
// more pass. The core works on one item at a time and takes no new item until
// the current one has left the sequencer; a finished result sits in the output
// register while the next item is already being worked on.
module modular_inverse_ext_euclid_core
  import mie_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  mie_in_if.sink                in_i,
  mie_out_if.source             out_o
);

  // operand, coefficient and divider widths
  localparam int unsigned W   = VALUE_BITS;
  localparam int unsigned OW  = (VALUE_BITS > DATA_W) ? VALUE_BITS : DATA_W;
  localparam int unsigned SW  = VALUE_BITS + 3;
  localparam int unsigned NUM_W = SW;

  seq_state_e state_q, state_d;

  logic [DATA_W-1:0]    modulus;
  logic [OW-1:0]        value_ext, modulus_ext;

  // euclid state: remainders and bezout coefficients of value
  logic [W-1:0]         r_prev_q, r_cur_q, m_q;
  logic signed [SW-1:0] s_prev_q, s_cur_q;
  logic [W-1:0]         inv_q;

  // output register
  logic                 out_valid_q;
  logic [DATA_W-1:0]    out_inv_q, out_gcd_q;
  logic                 out_flag_q;

  // sequencer controls
  logic                 accept;
  logic                 div_start;
  logic                 step_load;
  logic                 red_load;
  logic                 zero_inv;
  logic                 res_load;

  // divider operands and results
  logic [NUM_W-1:0]     div_num;
  logic [W-1:0]         div_den;
  logic signed [SW-1:0] div_mul;
  div_status_t          div_stat;
  logic [W-1:0]         div_rem;
  logic signed [SW-1:0] div_acc;

  logic                 s_neg;
  logic [SW-1:0]        s_mag;
  logic [W-1:0]         red_x;

  mie_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .modulus_o (modulus)
  );

  // operands are widened to OW bits; the datapath uses their low VALUE_BITS bits
  assign value_ext   = OW'(in_i.value);
  assign modulus_ext = OW'(modulus);

  assign accept = in_i.valid && in_i.ready;

  // magnitude of the final coefficient for the reduction pass
  assign s_neg = s_prev_q[SW-1];
  assign s_mag = s_neg ? SW'(-s_prev_q) : SW'(s_prev_q);

  // truncating remainder of a negative coefficient folded into 0..m-1
  always_comb begin
    if (!s_neg) begin
      red_x = div_rem;
    end else if (div_rem == '0) begin
      red_x = '0;
    end else begin
      red_x = m_q - div_rem;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (r_cur_q != '0) begin
          state_d = ST_DIVIDE;
        end else if (m_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_REDUCE;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) state_d = ST_CHECK;
      end
      ST_REDUCE: begin
        state_d = ST_REDUCE_WAIT;
      end
      ST_REDUCE_WAIT: begin
        if (div_stat.done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready = 1'b0;
    div_start  = 1'b0;
    step_load  = 1'b0;
    red_load   = 1'b0;
    zero_inv   = 1'b0;
    res_load   = 1'b0;
    div_num    = NUM_W'(r_prev_q);
    div_den    = r_cur_q;
    div_mul    = s_cur_q;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
      end
      ST_CHECK: begin
        div_start = (r_cur_q != '0);
        zero_inv  = (r_cur_q == '0) && (m_q == '0);
      end
      ST_DIVIDE: begin
        step_load = div_stat.done;
      end
      ST_REDUCE: begin
        div_start = 1'b1;
        div_num   = s_mag;
        div_den   = m_q;
        div_mul   = '0;
      end
      ST_REDUCE_WAIT: begin
        red_load = div_stat.done;
      end
      ST_FINISH: begin
        res_load = !out_valid_q || out_o.ready;
      end
      default: begin
      end
    endcase
  end

  mie_divider #(
    .NUM_W (NUM_W),
    .DEN_W (W),
    .ACC_W (SW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .mul_i    (div_mul),
    .status_o (div_stat),
    .rem_o    (div_rem),
    .acc_o    (div_acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // euclid datapath: r and s shift down one place per quotient step
  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_prev_q <= value_ext[W-1:0];
      r_cur_q  <= modulus_ext[W-1:0];
      m_q      <= modulus_ext[W-1:0];
      s_prev_q <= SW'(1);
      s_cur_q  <= '0;
    end else if (step_load) begin
      r_prev_q <= r_cur_q;
      r_cur_q  <= div_rem;
      s_prev_q <= s_cur_q;
      s_cur_q  <= s_prev_q - div_acc;
    end
    if (red_load) begin
      inv_q <= red_x;
    end else if (zero_inv) begin
      inv_q <= '0;
    end
  end

  // output register, free to take a result while the sequencer starts over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_inv_q  <= DATA_W'(inv_q);
      out_gcd_q  <= DATA_W'(r_prev_q);
      out_flag_q <= (r_prev_q != W'(1));
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.inverse        = out_inv_q;
  assign out_o.common_divisor = out_gcd_q;
  assign out_o.not_invertible = out_flag_q;

endmodule

// ===== rtl/core/mie_cfg_regs.sv =====
// apb register file holding the modulus
module mie_cfg_regs
  import mie_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [DATA_W-1:0]     modulus_o
);

  logic [DATA_W-1:0]    modulus_q, modulus_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 hit;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign hit     = (reg_idx == REG_MODULUS);
  assign pready  = 1'b1;

  always_comb begin
    modulus_d = modulus_q;
    if (psel && penable && pwrite && hit) begin
      modulus_d = pwdata[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET;
    end else begin
      modulus_q <= modulus_d;
    end
  end

  assign prdata    = hit ? APB_DATA_W'(modulus_q) : '0;
  assign modulus_o = modulus_q;

endmodule

// ===== rtl/core/mie_divider.sv =====
// radix-2 restoring divider with a horner multiply of the quotient alongside
module mie_divider
  import mie_pkg::*;
#(
  parameter int unsigned NUM_W = 35,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned ACC_W = 35
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NUM_W-1:0]        num_i,
  input  logic [DEN_W-1:0]        den_i,
  input  logic signed [ACC_W-1:0] mul_i,
  output div_status_t             status_o,
  output logic [DEN_W-1:0]        rem_o,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic                    busy_q, done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [NUM_W-1:0]        num_q;
  logic [DEN_W-1:0]        den_q, rem_q;
  logic signed [ACC_W-1:0] mul_q, acc_q;

  logic [DEN_W:0]          rem_sh;
  logic [DEN_W+1:0]        diff;
  logic                    qbit;
  logic [DEN_W-1:0]        rem_d;
  logic signed [ACC_W-1:0] acc_d;

  // one quotient bit per cycle, most significant first
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign qbit   = ~diff[DEN_W+1];
  assign rem_d  = qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  assign acc_d  = (acc_q <<< 1) + (qbit ? mul_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      mul_q <= mul_i;
      rem_q <= '0;
      acc_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= rem_d;
      acc_q <= acc_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;
  assign acc_o         = acc_q;

endmodule

// ===== test/testbench.sv =====
// self-checking testbench of the modular inverse core with directed and random items
module testbench
  import mie_pkg::*;
;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CLK_HALF = 10;
  localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;
  localparam int unsigned SETTLE_CYCLES = 2000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 57;
  localparam int unsigned MAX_PRINTED = 100;
  localparam logic [APB_ADDR_W-1:0] MODULUS_ADDR = {REG_MODULUS, 2'b00};
  // consecutive fibonacci numbers give the longest remainder sequence
  localparam logic [DATA_W-1:0] FIB_46 = 32'd1836311903;
  localparam logic [DATA_W-1:0] FIB_47 = 32'd2971215073;

  typedef struct packed {
    logic [DATA_W-1:0] inverse;
    logic [DATA_W-1:0] common_divisor;
    logic              not_invertible;
  } inverse_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  mie_in_if  in_if ();
  mie_out_if out_if ();

  modular_inverse_ext_euclid_core #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  inverse_result_t   pending_inverses[$];
  logic [DATA_W-1:0] modulus_copy;
  int unsigned       mismatch_count;
  longint unsigned   cycle_count;
  int unsigned       burst_left;
  bit                sender_paced;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // extended euclid on signed 64-bit terms, coefficient reduced into 0..m-1
  function automatic inverse_result_t compute_inverse(logic [DATA_W-1:0] value,
                                                      logic [DATA_W-1:0] modulus);
    logic [63:0]     op_mask;
    longint          rem_prev, rem_cur, rem_next;
    longint          coef_prev, coef_cur, coef_next;
    longint          quot, mod_used, reduced;
    inverse_result_t res;
    op_mask   = (64'd1 << VALUE_BITS) - 64'd1;
    rem_prev  = {32'd0, value} & op_mask;
    mod_used  = {32'd0, modulus} & op_mask;
    rem_cur   = mod_used;
    coef_prev = 1;
    coef_cur  = 0;
    while (rem_cur != 0) begin
      quot      = rem_prev / rem_cur;
      rem_next  = rem_prev - quot * rem_cur;
      coef_next = coef_prev - quot * coef_cur;
      rem_prev  = rem_cur;
      rem_cur   = rem_next;
      coef_prev = coef_cur;
      coef_cur  = coef_next;
    end
    res.common_divisor = rem_prev[DATA_W-1:0];
    if (mod_used == 0) begin
      res.inverse = '0;
    end else begin
      reduced = coef_prev % mod_used;
      if (reduced < 0) reduced += mod_used;
      res.inverse = reduced[DATA_W-1:0];
    end
    res.not_invertible = (rem_prev != 1);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("mismatch in %s: expected %0d, got %0d (cycle %0d)",
               what, want, got, cycle_count);
  endtask

  // one apb transfer, setup then access; read data taken at the completing edge
  task automatic apb_transfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_modulus_readback();
    logic [APB_DATA_W-1:0] rdata;
    apb_transfer(1'b0, MODULUS_ADDR, '0, rdata);
    if (rdata !== modulus_copy) report_mismatch("modulus readback", modulus_copy, rdata);
  endtask

  // hold the input side and wait until every outstanding result has arrived
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_inverses.size() != 0);
  endtask

  task automatic write_modulus(input logic [DATA_W-1:0] m);
    logic [APB_DATA_W-1:0] unused;
    drain_results();
    apb_transfer(1'b1, MODULUS_ADDR, m, unused);
    modulus_copy = m;
    check_modulus_readback();
  endtask

  // sender works in bursts; a gap may open before the first item of a burst
  task automatic send_value(input logic [DATA_W-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 1700) : $urandom_range(0, 6);
      if (sender_paced && gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    pending_inverses.push_back(compute_inverse(v, modulus_copy));
  endtask

  function automatic logic [DATA_W-1:0] pick_value(logic [DATA_W-1:0] m);
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom();
      4:          return $urandom_range(0, 300);
      5:          return m + $urandom_range(0, 600) - 32'd300;
      6:          return m * $urandom_range(0, 5);
      default:    return (32'd1 << $urandom_range(0, 31)) ^ ($urandom() & 32'h0000_00ff);
    endcase
  endfunction

  // default modulus straight after reset, including zero, one and values above it
  task automatic test_reset_modulus();
    check_modulus_readback();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd2);
    send_value(MODULUS_RESET - 32'd1);
    send_value(MODULUS_RESET);
    send_value(32'hffff_ffff);
    send_value(32'h8000_0000);
    send_value(32'd12345);
  endtask

  // largest modulus, modulus one, modulus zero and the smallest even one
  task automatic test_modulus_extremes();
    write_modulus(32'hffff_ffff);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_fffe);
    send_value(32'hffff_ffff);
    send_value(32'd65537);
    write_modulus(32'd1);
    send_value(32'd0);
    send_value(32'd5);
    send_value(32'hffff_ffff);
    write_modulus(32'd0);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd7);
    send_value(32'hffff_ffff);
    write_modulus(32'd2);
    send_value(32'd1);
    send_value(32'd2);
    send_value(32'd3);
  endtask

  task automatic test_slowest_operands();
    write_modulus(FIB_47);
    send_value(FIB_46);
    send_value(FIB_47 - 32'd1);
  endtask

  task automatic test_random_moduli();
    logic [DATA_W-1:0] m;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       m = $urandom() | 32'h8000_0000;
        1:       m = 32'hffff_ffff;
        2:       m = 32'd1 << $urandom_range(1, 31);
        3:       m = $urandom_range(1, 300);
        4:       m = MODULUS_RESET;
        default: m = $urandom_range(1, 32'h000f_ffff);
      endcase
      write_modulus(m);
      // one phase runs the sender back to back
      sender_paced = (phase != 3);
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_value(pick_value(modulus_copy));
        if (phase == 2 && i == ITEMS_PER_PHASE / 2) drain_results();
      end
    end
    sender_paced = 1'b1;
  endtask

  // receiver stalls on its own pattern: open, random, long block, periodic
  initial begin
    int unsigned stall_mode, span, period;
    logic        level;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall_mode = $urandom_range(0, 3);
      span       = $urandom_range(20, 1500);
      period     = $urandom_range(2, 9);
      if (stall_mode == 2) span = $urandom_range(1, 2500);
      for (int unsigned k = 0; k < span; k++) begin
        case (stall_mode)
          0:       level = 1'b1;
          1:       level = $urandom_range(0, 1);
          2:       level = 1'b0;
          default: level = (k % period) == 0;
        endcase
        out_if.ready <= level;
        @(posedge clk_i);
      end
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    inverse_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_inverses.size() == 0) begin
        report_mismatch("unexpected item", '0, out_if.inverse);
      end else begin
        want = pending_inverses.pop_front();
        if (out_if.inverse !== want.inverse)
          report_mismatch("inverse", want.inverse, out_if.inverse);
        if (out_if.common_divisor !== want.common_divisor)
          report_mismatch("common_divisor", want.common_divisor, out_if.common_divisor);
        if (out_if.not_invertible !== want.not_invertible)
          report_mismatch("not_invertible", want.not_invertible, out_if.not_invertible);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    modulus_copy   = MODULUS_RESET;
    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 0;
    sender_paced   = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_modulus();
    test_modulus_extremes();
    test_slowest_operands();
    test_random_moduli();
    drain_results();
    // give a stray extra result time to show up
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
